### hw/rtl/stint_pkg.sv
// ----------------------------------------------------------------------------
// stint_pkg
// Shared types and constants for the segment against triangle test core.
// ----------------------------------------------------------------------------
package stint_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BOX_W  = 31;
    localparam int unsigned EPS_W  = 17;
    localparam int unsigned MASK_W = 3;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned PD_W   = 31;

    localparam logic [IDX_W-1:0] REG_BOX_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_BOX_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_BOX_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_MASK  = 3'd3;
    localparam logic [IDX_W-1:0] REG_EPS   = 3'd4;

    localparam logic [2:0] SLOT_NORMAL = 3'd6;
    localparam logic [2:0] SLOT_NONE   = 3'd7;

    typedef enum logic [1:0] {
        OUT_HIT      = 2'd0,
        OUT_PARALLEL = 2'd1,
        OUT_BEYOND   = 2'd2,
        OUT_OUTSIDE  = 2'd3
    } outcome_t;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [2:0] vec_t;

    typedef struct packed {
        logic       query;
        logic [2:0] slot;
        vec_t       p;
        vec_t       d;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    typedef struct packed {
        logic [2:0][BOX_W-1:0] box;
        logic [MASK_W-1:0]     mask;
        logic [EPS_W-1:0]      eps;
    } cfg_t;

endpackage

### hw/rtl/stint_front.sv
// ----------------------------------------------------------------------------
// stint_front
// Accepts command words, drops loads aimed at no slot and hands the rest on.
// ----------------------------------------------------------------------------
module stint_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                req_type,
    input  logic [2:0]          slot,
    input  logic signed [31:0]  px,
    input  logic signed [31:0]  py,
    input  logic signed [31:0]  pz,
    input  logic signed [31:0]  dir_x,
    input  logic signed [31:0]  dir_y,
    input  logic signed [31:0]  dir_z,
    input  stint_pkg::qstat_t   qstat,
    output logic                busy,
    output logic                push,
    output stint_pkg::item_t    item
);

    logic             accept;
    logic             valid_reg;
    logic             valid_next;
    stint_pkg::item_t item_reg;
    stint_pkg::item_t item_next;

    always_comb
    begin
        accept          = start && !qstat.full;
        valid_next      = accept && (req_type || (slot != stint_pkg::SLOT_NONE));
        item_next.query = req_type;
        item_next.slot  = slot;
        item_next.p     = {pz, py, px};
        item_next.d     = {dir_z, dir_y, dir_x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign busy = qstat.full;
    assign push = valid_reg;
    assign item = item_reg;

endmodule

### hw/rtl/stint_queue.sv
// ----------------------------------------------------------------------------
// stint_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module stint_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  stint_pkg::item_t  item_in,
    input  logic              pop,
    output stint_pkg::item_t  item_out,
    output stint_pkg::qstat_t qstat
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    stint_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg;
    logic [PTR_W-1:0]   wr_next;
    logic [PTR_W-1:0]   rd_reg;
    logic [PTR_W-1:0]   rd_next;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;

    always_comb
    begin
        wr_next    = push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= item_in;
        end
    end

    // One place is kept free for the word already held in the front register.
    assign item_out    = mem_reg[rd_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg >= (PTR_W+1)'(DEPTH - 1));

endmodule

### hw/rtl/stint_back.sv
// ----------------------------------------------------------------------------
// stint_back
// Pipelined dot products, plane parameter division, wrap and side tests.
// ----------------------------------------------------------------------------
module stint_back
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  stint_pkg::cfg_t    cfg,
    input  stint_pkg::qstat_t  qstat,
    input  stint_pkg::item_t   item,
    output logic               pop,
    output logic               done,
    output logic               hit,
    output logic [1:0]         outcome,
    output logic [30:0]        plane_distance
);

    localparam int F  = FRAC_BITS;
    localparam int SW = 67;
    localparam int RW = 68;
    localparam int MW = 34 + FRAC_BITS;
    localparam int HW = 36;
    localparam logic signed [HW-1:0] HMAX = 36'sd2147483647;
    localparam logic signed [HW-1:0] HMIN = -36'sd2147483648;

    typedef struct packed {
        stint_pkg::vec_t      p;
        stint_pkg::vec_t      d;
        logic [8:0][31:0]     s;
        logic [2:0][SW-1:0]   sc;
        logic [30:0]          pd;
        stint_pkg::outcome_t  code;
    } car_t;

    logic [31:0]              store_reg [7][3];

    logic                     v1_reg;
    car_t                     car1_reg;
    logic signed [63:0]       mnd_reg [3];
    logic signed [63:0]       mnc_reg [3];
    logic signed [63:0]       mnp_reg [3];
    logic signed [63:0]       msc_reg [9];

    logic                     v2_reg;
    car_t                     car2_reg;
    logic signed [SW-1:0]     np2_reg;
    logic signed [SW-1:0]     dist2_reg;

    logic [SW-1:0]            ad;
    logic [SW-1:0]            an;
    logic [SW-1:0]            ad_hi;
    car_t                     car3_next;
    logic                     par;
    logic                     beyond;

    logic                     v_reg   [F+1];
    car_t                     car_reg [F+1];
    logic [SW-1:0]            an_reg  [F+1];
    logic                     eq_reg  [F+1];
    logic [RW-1:0]            r_reg   [F+1];
    logic [F-1:0]             q_reg   [F+1];

    logic [F:0]               aq;
    logic                     v4_reg;
    car_t                     car4_reg;
    logic signed [MW-1:0]     mh_reg [3];

    logic signed [HW-1:0]     h_sum [3];
    logic signed [HW-1:0]     h_wrap [3];
    logic signed [HW-1:0]     box_s [3];
    logic signed [HW-1:0]     eps_h;
    logic                     v5_reg;
    car_t                     car5_reg;
    logic signed [31:0]       h5_reg [3];

    logic                     v6_reg;
    car_t                     car6_reg;
    logic signed [63:0]       mhs_reg [9];

    logic signed [SW-1:0]     side [3];
    logic signed [SW-1:0]     lim;
    logic                     fail;
    stint_pkg::outcome_t      code_final;

    logic                     done_reg;
    logic                     hit_reg;
    stint_pkg::outcome_t      outcome_reg;
    logic [30:0]              pd_reg;

    assign pop = !qstat.empty;

    always_ff @(posedge clk)
    begin
        if (pop && !item.query && (item.slot != stint_pkg::SLOT_NONE))
        begin
            for (int i = 0; i < 3; i++)
            begin
                store_reg[item.slot][i] <= item.p[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v1_reg   <= pop && item.query;
            v2_reg   <= v1_reg;
            v_reg[0] <= v2_reg;
            v4_reg   <= v_reg[F];
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            done_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mnd_reg[i] <= $signed(store_reg[6][i]) * $signed(item.d[i]);
            mnc_reg[i] <= $signed(store_reg[6][i]) * $signed(store_reg[0][i]);
            mnp_reg[i] <= $signed(store_reg[6][i]) * $signed(item.p[i]);
            for (int k = 0; k < 3; k++)
            begin
                msc_reg[k*3+i] <= $signed(store_reg[3+k][i]) * $signed(store_reg[k][i]);
                car1_reg.s[k*3+i] <= store_reg[3+k][i];
            end
        end
        car1_reg.p    <= item.p;
        car1_reg.d    <= item.d;
        car1_reg.sc   <= '0;
        car1_reg.pd   <= '0;
        car1_reg.code <= stint_pkg::OUT_HIT;
    end

    always_ff @(posedge clk)
    begin
        car2_reg.p    <= car1_reg.p;
        car2_reg.d    <= car1_reg.d;
        car2_reg.s    <= car1_reg.s;
        car2_reg.pd   <= car1_reg.pd;
        car2_reg.code <= car1_reg.code;
        for (int k = 0; k < 3; k++)
        begin
            car2_reg.sc[k] <= SW'(msc_reg[k*3]) + SW'(msc_reg[k*3+1])
                              + SW'(msc_reg[k*3+2]);
        end
        np2_reg   <= SW'(mnd_reg[0]) + SW'(mnd_reg[1]) + SW'(mnd_reg[2]);
        dist2_reg <= SW'(mnc_reg[0]) + SW'(mnc_reg[1]) + SW'(mnc_reg[2])
                     - SW'(mnp_reg[0]) - SW'(mnp_reg[1]) - SW'(mnp_reg[2]);
    end

    always_comb
    begin
        ad     = dist2_reg[SW-1] ? SW'(-dist2_reg) : SW'(dist2_reg);
        an     = np2_reg[SW-1] ? SW'(-np2_reg) : SW'(np2_reg);
        ad_hi  = ad >> F;
        par    = (np2_reg == '0);
        beyond = ((dist2_reg[SW-1] != np2_reg[SW-1]) && (dist2_reg != '0)) || (ad > an);
        car3_next = car2_reg;
        if (par)
        begin
            car3_next.code = stint_pkg::OUT_PARALLEL;
            car3_next.pd   = '0;
        end
        else
        begin
            car3_next.code = beyond ? stint_pkg::OUT_BEYOND : stint_pkg::OUT_HIT;
            car3_next.pd   = (ad_hi > SW'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : ad_hi[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        car_reg[0] <= car3_next;
        an_reg[0]  <= an;
        eq_reg[0]  <= (ad == an);
        r_reg[0]   <= RW'(ad);
        q_reg[0]   <= '0;
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < F; k++)
    begin : g_div
        logic [RW-1:0] r2;
        logic          ge;

        always_comb
        begin
            r2 = {r_reg[k][RW-2:0], 1'b0};
            ge = (r2 >= RW'(an_reg[k]));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            car_reg[k+1] <= car_reg[k];
            an_reg[k+1]  <= an_reg[k];
            eq_reg[k+1]  <= eq_reg[k];
            r_reg[k+1]   <= ge ? r2 - RW'(an_reg[k]) : r2;
            q_reg[k+1]   <= {q_reg[k][F-2:0], ge};
        end
    end

    assign aq = eq_reg[F] ? (F+1)'(1) << F : {1'b0, q_reg[F]};

    always_ff @(posedge clk)
    begin
        car4_reg <= car_reg[F];
        for (int i = 0; i < 3; i++)
        begin
            mh_reg[i] <= $signed(car_reg[F].d[i]) * $signed({1'b0, aq});
        end
    end

    always_comb
    begin
        eps_h = HW'($signed(cfg.eps));
        for (int i = 0; i < 3; i++)
        begin
            box_s[i]  = $signed({5'b0, cfg.box[i]});
            h_sum[i]  = HW'($signed(car4_reg.p[i])) + HW'(mh_reg[i] >>> F);
            h_wrap[i] = h_sum[i];
            if (cfg.mask[i])
            begin
                if (h_sum[i] > box_s[i] - eps_h)
                begin
                    h_wrap[i] = h_sum[i] - box_s[i];
                end
                else if (h_sum[i] < eps_h)
                begin
                    h_wrap[i] = h_sum[i] + box_s[i];
                end
            end
            if (h_wrap[i] > HMAX)
            begin
                h_wrap[i] = HMAX;
            end
            else if (h_wrap[i] < HMIN)
            begin
                h_wrap[i] = HMIN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        car5_reg <= car4_reg;
        for (int i = 0; i < 3; i++)
        begin
            h5_reg[i] <= h_wrap[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        car6_reg <= car5_reg;
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mhs_reg[k*3+i] <= $signed(car5_reg.s[k*3+i]) * h5_reg[i];
            end
        end
    end

    always_comb
    begin
        lim  = SW'($signed(cfg.eps)) <<< F;
        fail = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            side[k] = SW'(mhs_reg[k*3]) + SW'(mhs_reg[k*3+1]) + SW'(mhs_reg[k*3+2])
                      - $signed(car6_reg.sc[k]);
            if (side[k] < lim)
            begin
                fail = 1'b1;
            end
        end
        if (car6_reg.code != stint_pkg::OUT_HIT)
        begin
            code_final = car6_reg.code;
        end
        else
        begin
            code_final = fail ? stint_pkg::OUT_OUTSIDE : stint_pkg::OUT_HIT;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= (code_final == stint_pkg::OUT_HIT);
        outcome_reg <= code_final;
        pd_reg      <= car6_reg.pd;
    end

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign outcome        = outcome_reg;
    assign plane_distance = pd_reg;

endmodule

### hw/rtl/segment_triangle_intersect_core.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersect_core
// Tests a segment against one stored triangle in signed fixed point.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while busy is low; loads give no result, queries one each.
// The division stages, one quotient bit each, set the latency.
// The receiver cannot stall, so busy stays low in normal use.
// Reset clears control state and the box and mask, and sets eps to all ones; the stored vectors are not cleared.
module segment_triangle_intersect_core
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [2:0]         slot,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    output logic               done,
    output logic               hit,
    output logic [1:0]         outcome,
    output logic [30:0]        plane_distance,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    stint_pkg::cfg_t   cfg_reg;
    stint_pkg::qstat_t qstat;
    stint_pkg::item_t  front_item;
    stint_pkg::item_t  queue_item;
    logic              push;
    logic              pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box  <= '0;
            cfg_reg.mask <= '0;
            cfg_reg.eps  <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stint_pkg::REG_BOX_X: cfg_reg.box[0] <= cfg_data;
                stint_pkg::REG_BOX_Y: cfg_reg.box[1] <= cfg_data;
                stint_pkg::REG_BOX_Z: cfg_reg.box[2] <= cfg_data;
                stint_pkg::REG_MASK:  cfg_reg.mask   <= cfg_data[2:0];
                stint_pkg::REG_EPS:   cfg_reg.eps    <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    stint_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .slot     (slot),
        .px       (px),
        .py       (py),
        .pz       (pz),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .qstat    (qstat),
        .busy     (busy),
        .push     (push),
        .item     (front_item)
    );

    stint_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (queue_item),
        .qstat    (qstat)
    );

    stint_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .qstat          (qstat),
        .item           (queue_item),
        .pop            (pop),
        .done           (done),
        .hit            (hit),
        .outcome        (outcome),
        .plane_distance (plane_distance)
    );

endmodule

### hw/rtl/stint_checker.sv
// ----------------------------------------------------------------------------
// stint_checker
// Port level checks on results of the segment against triangle core.
// ----------------------------------------------------------------------------
module stint_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic        hit,
    input logic [1:0]  outcome,
    input logic [30:0] plane_distance
);

    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit == (outcome == stint_pkg::OUT_HIT)))
        else $error("hit flag disagrees with outcome");

    a_par_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (outcome == stint_pkg::OUT_PARALLEL)) |-> (plane_distance == '0))
        else $error("parallel result carries a distance");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("core stalled although the back end never waits");

endmodule

bind segment_triangle_intersect_core stint_checker u_stint_checker (.*);
